[hdl/csb_pkg.sv]
// Shared types and constants for the cursor sequence buffer.
`timescale 1ns / 1ps

package csb_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OPCODE_W = 4;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 5;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START      = 4'd0,
        OP_ADVANCE    = 4'd1,
        OP_INSERT     = 4'd2,
        OP_ATTACH     = 4'd3,
        OP_REMOVE     = 4'd4,
        OP_REM_MATCH  = 4'd5,
        OP_INS_FRONT  = 4'd6,
        OP_REM_FRONT  = 4'd7,
        OP_ATTACH_END = 4'd8,
        OP_REM_END    = 4'd9,
        OP_READ       = 4'd10
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_NOCUR    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_TAKE_PREV,
        CELL_TAKE_NEXT
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      cmp_en;
        logic      cmp_valid;
    } cell_ctrl_t;

endpackage

[hdl/csb_cell.sv]
// One storage cell of the sequence chain: holds an entry, shifts, compares.
`timescale 1ns / 1ps

module csb_cell #(
    parameter int DATA_WIDTH = csb_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  csb_pkg::cell_ctrl_t   ctrl,
    input  logic [DATA_WIDTH-1:0] load_data,
    input  logic [DATA_WIDTH-1:0] prev_data,
    input  logic [DATA_WIDTH-1:0] next_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  match
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic                  match_reg;

    always_ff @(posedge clk)
    begin
        unique case (ctrl.cmd)
            csb_pkg::CELL_HOLD:      data_reg <= data_reg;
            csb_pkg::CELL_LOAD:      data_reg <= load_data;
            csb_pkg::CELL_TAKE_PREV: data_reg <= prev_data;
            csb_pkg::CELL_TAKE_NEXT: data_reg <= next_data;
            default:                 data_reg <= data_reg;
        endcase
        // match is sampled once per command, ahead of the update
        if (ctrl.cmp_en)
        begin
            match_reg <= ctrl.cmp_valid && (data_reg == load_data);
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

[hdl/cursor_sequence_buffer_top.sv]
// Top level of the cursor sequence buffer: control sequencer and cell chain.
// Usage:
//   Command channel: opcode, value and index are taken at a rising edge with
//   start high and busy low. busy is high while an operation is in flight.
//   Result channel: read_value, count, cursor, has_current and status are
//   valid for exactly one cycle, marked by done; the receiver cannot stall,
//   so every result transfer completes in the cycle it is shown.
//   Sequence: after the accepting edge the sequencer runs through a compare
//   pass over all cells, an update pass in which every cell shifts, loads
//   or holds in parallel, and a readout through the entry select mux into
//   the output registers, after which done rises.
//   The sequencer runs one command at a time; the next start is taken in
//   the cycle done is shown.
//   Reset: count and cursor go to zero, the list is empty; entry contents
//   are not cleared since only entries below count are ever read.
`timescale 1ns / 1ps

module cursor_sequence_buffer_top #(
    parameter int DEPTH      = csb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = csb_pkg::DATA_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [csb_pkg::OPCODE_W-1:0]   opcode,
    input  logic [csb_pkg::VALUE_W-1:0]    value,
    input  logic [csb_pkg::INDEX_W-1:0]    index,
    output logic                           done,
    output logic [csb_pkg::VALUE_W-1:0]    read_value,
    output logic [csb_pkg::COUNT_W-1:0]    count,
    output logic [csb_pkg::COUNT_W-1:0]    cursor,
    output logic                           has_current,
    output logic [csb_pkg::STATUS_W-1:0]   status
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int IW    = (CNT_W > csb_pkg::INDEX_W) ? CNT_W : csb_pkg::INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_EXEC,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_OPEN,
        SH_CLOSE
    } shift_t;

    state_t                        state_reg;
    logic [csb_pkg::OPCODE_W-1:0]  op_reg;
    logic [DATA_WIDTH-1:0]         val_reg;
    logic [csb_pkg::INDEX_W-1:0]   idx_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              cur_reg;
    csb_pkg::status_t              st_reg;

    logic                          done_reg;
    logic [csb_pkg::VALUE_W-1:0]   read_value_reg;
    logic [csb_pkg::COUNT_W-1:0]   count_out_reg;
    logic [csb_pkg::COUNT_W-1:0]   cursor_out_reg;
    logic                          has_cur_reg;
    logic [csb_pkg::STATUS_W-1:0]  status_out_reg;

    logic [DATA_WIDTH-1:0]         val_masked;
    logic [DATA_WIDTH-1:0]         cell_data [DEPTH];
    logic [DEPTH-1:0]              match_vec;
    logic [DEPTH-1:0]              match_pre;
    logic [DEPTH-1:0]              match_first;
    logic [CNT_W-1:0]              match_pos;
    logic                          found;
    csb_pkg::cell_ctrl_t           cell_ctrl [DEPTH];

    csb_pkg::status_t              exec_st;
    shift_t                        exec_shift;
    logic [CNT_W-1:0]              exec_pos;
    logic [CNT_W-1:0]              count_next;
    logic [CNT_W-1:0]              cur_next;
    logic                          full;
    logic                          has_item;

    logic [IW-1:0]                 idx_ext;
    logic [IW-1:0]                 cnt_ext;
    logic [IDX_W-1:0]              sel;
    logic [DATA_WIDTH-1:0]         sel_data;
    logic [DATA_WIDTH-1:0]         rv_data;
    logic [csb_pkg::VALUE_W-1:0]   rv_wide;

    // value is masked to the stored width; upper stored bits stay zero
    always_comb
    begin
        for (int b = 0; b < DATA_WIDTH; b++)
        begin
            val_masked[b] = (b < csb_pkg::VALUE_W) ? value[b % csb_pkg::VALUE_W] : 1'b0;
        end
    end

    // cell chain: each cell sees its two neighbors; an end cell sees itself on its open side
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] prev_d;
        logic [DATA_WIDTH-1:0] next_d;
        if (i == 0)
        begin : g_first
            assign prev_d = cell_data[i];
        end
        else
        begin : g_mid_prev
            assign prev_d = cell_data[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign next_d = cell_data[i];
        end
        else
        begin : g_mid_next
            assign next_d = cell_data[i+1];
        end

        csb_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl[i]),
            .load_data (val_reg),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[i]),
            .match     (match_vec[i])
        );

        assign match_pre[i] = |match_vec[i:0];
        if (i == 0)
        begin : g_first_match
            assign match_first[i] = match_vec[i];
        end
        else
        begin : g_next_match
            assign match_first[i] = match_vec[i] & ~match_pre[i-1];
        end
    end

    assign found = match_pre[DEPTH-1];

    always_comb
    begin
        match_pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match_first[i])
            begin
                match_pos = match_pos | CNT_W'(i);
            end
        end
    end

    assign full     = (count_reg >= CNT_W'(DEPTH));
    assign has_item = (cur_reg < count_reg);
    assign idx_ext  = IW'(idx_reg);
    assign cnt_ext  = IW'(count_reg);

    // operation decode for the update pass
    always_comb
    begin
        exec_st    = csb_pkg::ST_OK;
        exec_shift = SH_NONE;
        exec_pos   = '0;
        cur_next   = cur_reg;
        unique case (op_reg)
            csb_pkg::OP_START:
            begin
                cur_next = '0;
            end
            csb_pkg::OP_ADVANCE:
            begin
                if (!has_item)
                    exec_st = csb_pkg::ST_NOCUR;
                else
                    cur_next = cur_reg + CNT_W'(1);
            end
            csb_pkg::OP_INSERT:
            begin
                if (full)
                    exec_st = csb_pkg::ST_FULL;
                else
                begin
                    exec_shift = SH_OPEN;
                    exec_pos   = has_item ? cur_reg : '0;
                    cur_next   = exec_pos;
                end
            end
            csb_pkg::OP_ATTACH:
            begin
                if (full)
                    exec_st = csb_pkg::ST_FULL;
                else
                begin
                    exec_shift = SH_OPEN;
                    exec_pos   = has_item ? (cur_reg + CNT_W'(1)) : count_reg;
                    cur_next   = exec_pos;
                end
            end
            csb_pkg::OP_REMOVE:
            begin
                if (!has_item)
                    exec_st = csb_pkg::ST_NOCUR;
                else
                begin
                    exec_shift = SH_CLOSE;
                    exec_pos   = cur_reg;
                end
            end
            csb_pkg::OP_REM_MATCH:
            begin
                if (!found)
                    exec_st = csb_pkg::ST_NOTFOUND;
                else
                begin
                    exec_shift = SH_CLOSE;
                    exec_pos   = match_pos;
                    cur_next   = match_pos;
                end
            end
            csb_pkg::OP_INS_FRONT:
            begin
                if (full)
                    exec_st = csb_pkg::ST_FULL;
                else
                begin
                    exec_shift = SH_OPEN;
                    cur_next   = '0;
                end
            end
            csb_pkg::OP_REM_FRONT:
            begin
                if (count_reg == '0)
                    exec_st = csb_pkg::ST_NOCUR;
                else
                begin
                    exec_shift = SH_CLOSE;
                    cur_next   = '0;
                end
            end
            csb_pkg::OP_ATTACH_END:
            begin
                if (full)
                    exec_st = csb_pkg::ST_FULL;
                else
                begin
                    exec_shift = SH_OPEN;
                    exec_pos   = count_reg;
                    cur_next   = count_reg;
                end
            end
            csb_pkg::OP_REM_END:
            begin
                if (count_reg != '0)
                begin
                    exec_shift = SH_CLOSE;
                    exec_pos   = count_reg - CNT_W'(1);
                    cur_next   = exec_pos;
                end
            end
            csb_pkg::OP_READ:
            begin
                if (idx_ext >= cnt_ext)
                    exec_st = csb_pkg::ST_RANGE;
            end
            default:
            begin
                exec_st = csb_pkg::ST_OK;
            end
        endcase

        unique case (exec_shift)
            SH_OPEN:  count_next = count_reg + CNT_W'(1);
            SH_CLOSE: count_next = count_reg - CNT_W'(1);
            default:  count_next = count_reg;
        endcase
    end

    // per-cell commands
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_ctrl[i].cmd       = csb_pkg::CELL_HOLD;
            cell_ctrl[i].cmp_en    = (state_reg == S_MATCH);
            cell_ctrl[i].cmp_valid = (CNT_W'(i) < count_reg);
            if (state_reg == S_EXEC)
            begin
                priority if (exec_shift == SH_OPEN && CNT_W'(i) == exec_pos)
                    cell_ctrl[i].cmd = csb_pkg::CELL_LOAD;
                else if (exec_shift == SH_OPEN && CNT_W'(i) > exec_pos)
                    cell_ctrl[i].cmd = csb_pkg::CELL_TAKE_PREV;
                else if (exec_shift == SH_CLOSE && CNT_W'(i) >= exec_pos)
                    cell_ctrl[i].cmd = csb_pkg::CELL_TAKE_NEXT;
                else
                    cell_ctrl[i].cmd = csb_pkg::CELL_HOLD;
            end
        end
    end

    // readout select
    assign sel      = (op_reg == csb_pkg::OP_READ) ? idx_ext[IDX_W-1:0] : cur_reg[IDX_W-1:0];
    assign sel_data = cell_data[sel];

    always_comb
    begin
        if (op_reg == csb_pkg::OP_READ)
            rv_data = (st_reg == csb_pkg::ST_OK) ? sel_data : '0;
        else
            rv_data = has_item ? sel_data : '0;
    end

    for (genvar b = 0; b < csb_pkg::VALUE_W; b++)
    begin : g_rv
        if (b < DATA_WIDTH)
        begin : g_bit
            assign rv_wide[b] = rv_data[b];
        end
        else
        begin : g_zero
            assign rv_wide[b] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            cur_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= opcode;
                        val_reg   <= val_masked;
                        idx_reg   <= index;
                        state_reg <= S_MATCH;
                    end
                end
                S_MATCH:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    count_reg <= count_next;
                    cur_reg   <= cur_next;
                    st_reg    <= exec_st;
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    done_reg       <= 1'b1;
                    read_value_reg <= rv_wide;
                    count_out_reg  <= csb_pkg::COUNT_W'(count_reg);
                    cursor_out_reg <= csb_pkg::COUNT_W'(cur_reg);
                    has_cur_reg    <= has_item;
                    status_out_reg <= st_reg;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign read_value  = read_value_reg;
    assign count       = count_out_reg;
    assign cursor      = cursor_out_reg;
    assign has_current = has_cur_reg;
    assign status      = status_out_reg;

endmodule
